/* hdl/swsr_pkg.sv */
// Shared types and codes for the single-wire sensor reader.
// No dependencies; used by swsr_fsm and single_wire_sensor_reader_top.
package swsr_pkg;

    // Response status codes
    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_OK   = 2'd1;
    localparam logic [1:0] RESP_BAD  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_LOW   = 3'd0;
    localparam logic [2:0] CFG_START_HIGH  = 3'd1;
    localparam logic [2:0] CFG_RESP_WAIT   = 3'd2;
    localparam logic [2:0] CFG_RESP_GAP    = 3'd3;
    localparam logic [2:0] CFG_BIT_SAMPLE  = 3'd4;
    localparam logic [2:0] CFG_FRAME_BYTES = 3'd5;

    // Timing and frame configuration
    typedef struct packed {
        logic [7:0] start_low_ticks;
        logic [7:0] start_high_ticks;
        logic [7:0] response_wait_ticks;
        logic [7:0] response_gap_ticks;
        logic [7:0] bit_sample_ticks;
        logic [3:0] bytes_per_frame;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       response_valid;
        logic [1:0] response_status;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       frame_last;
        logic       busy_res;
    } res_t;

endpackage

/* hdl/swsr_fsm.sv */
// Exchange sequencer: phase state, tick counter, bit and byte shifting.
// Depends on swsr_pkg for the configuration and result types.
module swsr_fsm (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            func,
    input  logic            pin_level,
    input  swsr_pkg::cfg_t  cfg,
    output swsr_pkg::res_t  result
);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_START_LOW  = 4'd1;
    localparam logic [3:0] PH_START_HIGH = 4'd2;
    localparam logic [3:0] PH_RESP_WAIT  = 4'd3;
    localparam logic [3:0] PH_RESP_GAP   = 4'd4;
    localparam logic [3:0] PH_RESP_LOW   = 4'd5;
    localparam logic [3:0] PH_BIT_HIGH   = 4'd6;
    localparam logic [3:0] PH_BIT_DELAY  = 4'd7;
    localparam logic [3:0] PH_BIT_LOW    = 4'd8;

    logic [3:0] phase_reg, phase_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [2:0] byte_index_reg, byte_index_next;

    logic [7:0] tick_inc;
    logic [3:0] frame_len;
    logic [3:0] byte_count;
    logic       resp_valid;
    logic [1:0] resp_status;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       frame_last;

    // Clamp frame length to 1..8
    always_comb begin
        if (cfg.bytes_per_frame == 4'd0) begin
            frame_len = 4'd1;
        end else if (cfg.bytes_per_frame > 4'd8) begin
            frame_len = 4'd8;
        end else begin
            frame_len = cfg.bytes_per_frame;
        end
    end

    assign tick_inc   = tick_count_reg + 8'd1;
    assign byte_count = {1'b0, byte_index_reg} + 4'd1;

    // Next-state logic for one item
    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        byte_index_next = byte_index_reg;
        resp_valid      = 1'b0;
        resp_status     = swsr_pkg::RESP_NONE;
        byte_valid      = 1'b0;
        byte_value      = 8'd0;
        frame_last      = 1'b0;
        if (func) begin
            // Start command: abandon any exchange and drive low
            phase_next      = PH_START_LOW;
            tick_count_next = 8'd0;
            bit_index_next  = 3'd0;
            shift_byte_next = 8'd0;
            byte_index_next = 3'd0;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                end
                PH_START_LOW: begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg.start_low_ticks) begin
                        phase_next      = PH_START_HIGH;
                        tick_count_next = 8'd0;
                    end
                end
                PH_START_HIGH: begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg.start_high_ticks) begin
                        phase_next      = PH_RESP_WAIT;
                        tick_count_next = 8'd0;
                    end
                end
                PH_RESP_WAIT: begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg.response_wait_ticks) begin
                        tick_count_next = 8'd0;
                        if (!pin_level) begin
                            phase_next = PH_RESP_GAP;
                        end else begin
                            resp_valid  = 1'b1;
                            resp_status = swsr_pkg::RESP_NONE;
                            phase_next  = PH_RESP_LOW;
                        end
                    end
                end
                PH_RESP_GAP: begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg.response_gap_ticks) begin
                        tick_count_next = 8'd0;
                        resp_valid      = 1'b1;
                        resp_status     = pin_level ? swsr_pkg::RESP_OK : swsr_pkg::RESP_BAD;
                        phase_next      = PH_RESP_LOW;
                    end
                end
                PH_RESP_LOW: begin
                    if (!pin_level) begin
                        bit_index_next  = 3'd0;
                        byte_index_next = 3'd0;
                        shift_byte_next = 8'd0;
                        phase_next      = PH_BIT_HIGH;
                    end
                end
                PH_BIT_HIGH: begin
                    if (pin_level) begin
                        tick_count_next = 8'd0;
                        phase_next      = PH_BIT_DELAY;
                    end
                end
                PH_BIT_DELAY: begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg.bit_sample_ticks) begin
                        tick_count_next = 8'd0;
                        shift_byte_next = {shift_byte_reg[6:0], pin_level};
                        phase_next      = PH_BIT_LOW;
                    end
                end
                PH_BIT_LOW: begin
                    if (!pin_level) begin
                        if (bit_index_reg == 3'd7) begin
                            // Byte complete: emit it
                            byte_valid      = 1'b1;
                            byte_value      = shift_byte_reg;
                            frame_last      = (byte_count >= frame_len);
                            bit_index_next  = 3'd0;
                            shift_byte_next = 8'd0;
                            if (frame_last) begin
                                byte_index_next = 3'd0;
                                phase_next      = PH_IDLE;
                            end else begin
                                byte_index_next = byte_index_reg + 3'd1;
                                phase_next      = PH_BIT_HIGH;
                            end
                        end else begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_BIT_HIGH;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Advance state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= 8'd0;
            bit_index_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
            byte_index_reg <= 3'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            byte_index_reg <= byte_index_next;
        end
    end

    // Result reflects the state after this item
    always_comb begin
        result.drive_enable    = (phase_next == PH_START_LOW) || (phase_next == PH_START_HIGH);
        result.drive_level     = (phase_next == PH_START_HIGH);
        result.response_valid  = resp_valid;
        result.response_status = resp_status;
        result.byte_valid      = byte_valid;
        result.byte_value      = byte_value;
        result.frame_last      = frame_last;
        result.busy_res        = (phase_next != PH_IDLE);
    end

`ifndef NO_ASSERTIONS
    a_start_enters_low: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && func |=> phase_reg == PH_START_LOW)
        else $error("start command did not enter start-low phase");

    a_idle_counters_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> tick_count_reg == 8'd0 && bit_index_reg == 3'd0
            && byte_index_reg == 3'd0)
        else $error("counters not clear while idle");

    a_byte_only_in_bit_low: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_valid |-> phase_reg == PH_BIT_LOW && bit_index_reg == 3'd7)
        else $error("byte emitted outside last bit of a byte");
`endif

endmodule

/* hdl/single_wire_sensor_reader_top.sv */
// A result item is presented in the cycle after its input item is accepted.
// Throughput: one item per cycle while results are taken; the whole phase update is one registered step.
// The output register lets a new item enter while the previous result is taken.
// Reset (aresetn low, synchronous): phase idle, counters clear, output empty,
// timing registers back to 120/3/4/8/4 ticks and a five-byte frame.
// Top level: configuration registers, sequencer and output register.
// Depends on swsr_pkg and swsr_fsm.
module single_wire_sensor_reader_top (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    // Input item channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic       s_pin_level,
    // Result item channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_drive_enable,
    output logic       m_drive_level,
    output logic       m_response_valid,
    output logic [1:0] m_response_status,
    output logic       m_byte_valid,
    output logic [7:0] m_byte_value,
    output logic       m_frame_last,
    output logic       m_busy_res
);

    swsr_pkg::cfg_t cfg_reg;
    swsr_pkg::res_t result;
    swsr_pkg::res_t out_reg;
    logic           m_valid_reg, m_valid_next;
    logic           advance;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks     <= 8'd120;
            cfg_reg.start_high_ticks    <= 8'd3;
            cfg_reg.response_wait_ticks <= 8'd4;
            cfg_reg.response_gap_ticks  <= 8'd8;
            cfg_reg.bit_sample_ticks    <= 8'd4;
            cfg_reg.bytes_per_frame     <= 4'd5;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                swsr_pkg::CFG_START_LOW:   cfg_reg.start_low_ticks     <= cfg_data;
                swsr_pkg::CFG_START_HIGH:  cfg_reg.start_high_ticks    <= cfg_data;
                swsr_pkg::CFG_RESP_WAIT:   cfg_reg.response_wait_ticks <= cfg_data;
                swsr_pkg::CFG_RESP_GAP:    cfg_reg.response_gap_ticks  <= cfg_data;
                swsr_pkg::CFG_BIT_SAMPLE:  cfg_reg.bit_sample_ticks    <= cfg_data;
                swsr_pkg::CFG_FRAME_BYTES: cfg_reg.bytes_per_frame     <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Take an item whenever the output register is empty or being drained
    assign s_ready      = !m_valid_reg || m_ready;
    assign advance      = s_valid && s_ready;
    assign m_valid_next = advance || (m_valid_reg && !m_ready);

    swsr_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .func      (s_func),
        .pin_level (s_pin_level),
        .cfg       (cfg_reg),
        .result    (result)
    );

    // Output register: hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_drive_enable    = out_reg.drive_enable;
    assign m_drive_level     = out_reg.drive_level;
    assign m_response_valid  = out_reg.response_valid;
    assign m_response_status = out_reg.response_status;
    assign m_byte_valid      = out_reg.byte_valid;
    assign m_byte_value      = out_reg.byte_value;
    assign m_frame_last      = out_reg.frame_last;
    assign m_busy_res        = out_reg.busy_res;

`ifndef NO_ASSERTIONS
    a_resp_byte_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_response_valid && m_byte_valid))
        else $error("response and byte reported in the same item");

    a_drive_high_driven: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_level |-> m_drive_enable && m_busy_res)
        else $error("drive level high while line released");

    a_last_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_byte_valid && !m_busy_res)
        else $error("frame end flagged without a byte or while still busy");

    a_status_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_response_valid |-> m_response_status == swsr_pkg::RESP_NONE)
        else $error("response status set without response");
`endif

endmodule
